// File: src/cfd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfd_pkg
// Shared widths, reset values and the slot-to-channel order map for the
// combined ppm frame decoder.
// ----------------------------------------------------------------------------
package cfd_pkg;

  localparam int TimeW            = 16;
  localparam int SlotW            = 4;
  localparam int DataW            = 32;
  localparam int AddrW            = 3;
  localparam int MaxChannelsDflt  = 8;

  localparam logic [TimeW-1:0] SyncResetTicks = 16'd3000;

  // register indexes (word address bits of paddr)
  localparam logic RegSyncThreshold = 1'b0;

  typedef struct packed {
    logic             width_valid;
    logic [SlotW-1:0] channel_index;
    logic [TimeW-1:0] pulse_width;
    logic             frame_complete;
    logic             sync_locked;
    logic [SlotW-1:0] learned_channels;
  } cfd_result_t;

  // slots 1,2,3 land on channels 3,1,2, the rest map to themselves
  function automatic logic [SlotW-1:0] map_slot(input logic [SlotW-1:0] slot);
    logic [SlotW-1:0] chan;
    unique case (slot)
      SlotW'(1): chan = SlotW'(3);
      SlotW'(2): chan = SlotW'(1);
      SlotW'(3): chan = SlotW'(2);
      default:   chan = slot;
    endcase
    return chan;
  endfunction

endpackage

// File: src/cppm_frame_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cppm_frame_decoder
// Turns edge capture timestamps of a combined ppm train into channel widths.
// ----------------------------------------------------------------------------
// One timestamp word is taken per clock. Its result word is registered into
// the output register, or into a single skid entry behind it while the
// output is stalled, so the input keeps flowing through output stall and
// only stalls once both entries hold words. The whole per-edge
// update (gap test, slot step, learned-maximum compare) is one pass of logic
// from the decoder state to the output register. sync_threshold is written
// through the apb port and should only change while no words are in flight.
module cppm_frame_decoder
  import cfd_pkg::*;
#(
  parameter int MAX_CHANNELS = MaxChannelsDflt
) (
  input  logic             clk,
  input  logic             rst,
  // apb register port
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  // edge timestamp channel
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [TimeW-1:0] capture_time,
  // result channel
  output logic             out_valid,
  input  logic             out_stall,
  output logic             width_valid,
  output logic [SlotW-1:0] channel_index,
  output logic [TimeW-1:0] pulse_width,
  output logic             frame_complete,
  output logic             sync_locked,
  output logic [SlotW-1:0] learned_channels
);

  localparam logic [SlotW-1:0] SlotMax = SlotW'(MAX_CHANNELS);

  logic [TimeW-1:0] sync_threshold;
  logic [TimeW-1:0] last_edge_time;
  logic [TimeW-1:0] slot_start_time;
  logic [SlotW-1:0] slot_count;
  logic [SlotW-1:0] max_slot_count;
  logic             lock_flag;

  logic [TimeW-1:0] slot_start_time_next;
  logic [SlotW-1:0] slot_count_next;
  logic [SlotW-1:0] max_slot_count_next;
  logic             lock_flag_next;

  cfd_result_t res_next;
  cfd_result_t out_res;
  cfd_result_t skid_res;
  logic        skid_full;

  logic             in_acc;
  logic             cfg_wr;
  logic [TimeW-1:0] gap;
  logic [SlotW-1:0] slot_base;

  assign in_stall = skid_full;
  assign in_acc   = in_valid && !skid_full;

  // register port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[AddrW-1] == RegSyncThreshold);
  assign prdata = (paddr[AddrW-1] == RegSyncThreshold) ? DataW'(sync_threshold) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_threshold <= SyncResetTicks;
    end else if (cfg_wr) begin
      sync_threshold <= pwdata[TimeW-1:0];
    end
  end

  // per-edge decode
  always_comb begin
    gap       = capture_time - last_edge_time;
    slot_base = (gap > sync_threshold) ? '0 : slot_count;

    res_next             = '0;
    slot_start_time_next = slot_start_time;
    lock_flag_next       = lock_flag;
    max_slot_count_next  = max_slot_count;

    if (slot_base == '0) begin
      // first edge of a frame only marks the start
      slot_start_time_next = capture_time;
      slot_count_next      = SlotW'(1);
    end else if (slot_base <= SlotMax) begin
      res_next.width_valid   = 1'b1;
      res_next.channel_index = map_slot(slot_base);
      res_next.pulse_width   = capture_time - slot_start_time;
      slot_start_time_next   = capture_time;
      slot_count_next        = slot_base + SlotW'(1);
    end else begin
      // slots ran past the channel count
      slot_count_next         = slot_base;
      res_next.frame_complete = 1'b1;
      lock_flag_next          = 1'b1;
    end

    if (slot_count_next > max_slot_count) begin
      max_slot_count_next = slot_count_next;
    end else if (slot_count_next == max_slot_count) begin
      res_next.frame_complete = 1'b1;
      lock_flag_next          = 1'b1;
    end

    res_next.sync_locked      = lock_flag_next;
    res_next.learned_channels = max_slot_count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_edge_time  <= '0;
      slot_start_time <= '0;
      slot_count      <= '0;
      max_slot_count  <= '0;
      lock_flag       <= 1'b0;
    end else if (in_acc) begin
      last_edge_time  <= capture_time;
      slot_start_time <= slot_start_time_next;
      slot_count      <= slot_count_next;
      max_slot_count  <= max_slot_count_next;
      lock_flag       <= lock_flag_next;
    end
  end

  // output register with one skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_full <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      if (skid_full) begin
        out_valid <= 1'b1;
        skid_full <= 1'b0;
      end else begin
        out_valid <= in_acc;
      end
    end else if (in_acc) begin
      skid_full <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || !out_stall) begin
      if (skid_full) begin
        out_res <= skid_res;
      end else if (in_acc) begin
        out_res <= res_next;
      end
    end else if (in_acc) begin
      skid_res <= res_next;
    end
  end

  assign width_valid      = out_res.width_valid;
  assign channel_index    = out_res.channel_index;
  assign pulse_width      = out_res.pulse_width;
  assign frame_complete   = out_res.frame_complete;
  assign sync_locked      = out_res.sync_locked;
  assign learned_channels = out_res.learned_channels;

endmodule

// File: src/cfd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfd_checker
// Port-level checks on the decoder result channel, bound into cppm_frame_decoder.
// ----------------------------------------------------------------------------
module cfd_checker
  import cfd_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             out_valid,
  input logic             out_stall,
  input logic             width_valid,
  input logic [SlotW-1:0] channel_index,
  input logic [TimeW-1:0] pulse_width,
  input logic             frame_complete,
  input logic             sync_locked,
  input logic [SlotW-1:0] learned_channels
);

  // a held word stays put
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(pulse_width)
      && $stable(channel_index) && $stable(width_valid))
    else $error("result word changed while stalled");

  // no width means empty channel and width fields
  a_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && !width_valid |-> channel_index == '0 && pulse_width == '0)
    else $error("fields set on a word without a width");

  // a width always lands on a real channel, after at least one slot learned
  a_chan: assert property (@(posedge clk) disable iff (rst)
    out_valid && width_valid |-> channel_index != '0 && learned_channels != '0)
    else $error("width on channel zero or with nothing learned");

  // complete frame implies lock
  a_lock: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_complete |-> sync_locked)
    else $error("frame complete without lock");

  // lock is sticky
  a_sticky: assert property (@(posedge clk) disable iff (rst)
    out_valid && sync_locked |=> sync_locked)
    else $error("lock dropped");

endmodule

bind cppm_frame_decoder cfd_checker u_cfd_checker (.*);

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the combined ppm frame decoder against its own edge-by-edge
// predictor. The timestamp words come from directed frames, frames at
// threshold extremes and random pulse trains. Sender gaps and result stalls
// are random, and sync_threshold is rewritten through the apb port between
// phases.
// ----------------------------------------------------------------------------
module tb_top;
  import cfd_pkg::*;

  localparam int NumChannels = MaxChannelsDflt;
  localparam int StallLimit  = 2000;
  localparam logic [AddrW-1:0] SyncThrAddr = AddrW'({RegSyncThreshold, 2'b00});

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             psel = 1'b0;
  logic             penable = 1'b0;
  logic             pwrite = 1'b0;
  logic [AddrW-1:0] paddr = '0;
  logic [DataW-1:0] pwdata = '0;
  logic [DataW-1:0] prdata;
  logic             pready;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [TimeW-1:0] capture_time = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic             width_valid;
  logic [SlotW-1:0] channel_index;
  logic [TimeW-1:0] pulse_width;
  logic             frame_complete;
  logic             sync_locked;
  logic [SlotW-1:0] learned_channels;

  // decoder state as predicted
  logic [TimeW-1:0] m_thr = SyncResetTicks;
  logic [TimeW-1:0] m_last = '0;
  logic [TimeW-1:0] m_start = '0;
  logic [SlotW-1:0] m_slot = '0;
  logic [SlotW-1:0] m_max = '0;
  logic             m_lock = 1'b0;

  cfd_result_t      pending_results[$];
  logic [TimeW-1:0] tx_time = '0;
  int               gap_pct = 0;
  int               stall_pct = 0;
  int               n_sent = 0;
  int               n_checked = 0;
  int               n_widths = 0;
  int               n_complete = 0;
  int               n_errors = 0;
  int               quiet_cycles = 0;

  cppm_frame_decoder #(
    .MAX_CHANNELS(NumChannels)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .capture_time(capture_time),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .width_valid(width_valid),
    .channel_index(channel_index),
    .pulse_width(pulse_width),
    .frame_complete(frame_complete),
    .sync_locked(sync_locked),
    .learned_channels(learned_channels)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [SlotW-1:0] slot_to_channel(input logic [SlotW-1:0] slot);
    case (slot)
      SlotW'(1): return SlotW'(3);
      SlotW'(2): return SlotW'(1);
      SlotW'(3): return SlotW'(2);
      default:   return slot;
    endcase
  endfunction

  // one edge through the decoder: gap test, slot step, learned-maximum compare
  function automatic cfd_result_t decode_edge(input logic [TimeW-1:0] t);
    cfd_result_t      r;
    logic [TimeW-1:0] gap;
    r   = '0;
    gap = t - m_last;
    if (gap > m_thr) m_slot = '0;
    m_last = t;
    if (m_slot == '0) begin
      m_start = t;
      m_slot  = SlotW'(1);
    end else if (m_slot <= SlotW'(NumChannels)) begin
      r.width_valid   = 1'b1;
      r.channel_index = slot_to_channel(m_slot);
      r.pulse_width   = t - m_start;
      m_start         = t;
      m_slot          = m_slot + SlotW'(1);
    end else begin
      r.frame_complete = 1'b1;
      m_lock           = 1'b1;
    end
    if (m_slot > m_max) begin
      m_max = m_slot;
    end else if (m_slot == m_max) begin
      r.frame_complete = 1'b1;
      m_lock           = 1'b1;
    end
    r.sync_locked      = m_lock;
    r.learned_channels = m_max;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    n_errors++;
    if (n_errors <= 40)
      $display("[%0t] mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
  endtask

  task automatic send_edge(input logic [TimeW-1:0] t);
    if ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < gap_pct);
    end
    in_valid     <= 1'b1;
    capture_time <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(decode_edge(t));
    tx_time = t;
    n_sent++;
  endtask

  task automatic send_step(input int unsigned delta);
    send_edge(TimeW'(tx_time + delta));
  endtask

  // sender holds off until every pending result has been checked
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_sync_threshold(input logic [TimeW-1:0] value);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    paddr   <= SyncThrAddr;
    pwdata  <= DataW'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    m_thr = value;
    // read back
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== DataW'(value)) report_mismatch("sync_threshold readback", prdata, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // optional sync gap, then the requested number of timestamps spaced within the threshold
  task automatic send_frame(input int n_edges, input bit lead_sync);
    int unsigned hi;
    int unsigned lo;
    if (lead_sync && m_thr != '1) send_step($urandom_range(int'(m_thr) + 1, 65535));
    hi = (m_thr < 2300) ? m_thr : 2300;
    lo = (hi < 700) ? 0 : 700;
    repeat (n_edges) send_step($urandom_range(lo, hi));
  endtask

  task automatic test_first_frames();
    gap_pct   = 20;
    stall_pct = 46;
    // first edge is measured against a zero timestamp
    send_edge(TimeW'(100));
    send_step(1500);
    send_step(7400);
    send_step(1000);
    send_step(2000);
    // gap equal to the threshold is not sync
    send_step(3000);
    send_step(1);
    send_step(60000);
    // zero width, then reach the learned count again
    send_step(0);
    repeat (3) send_step(1500);
    // frame across the timer wrap, running into slot overflow
    send_edge('1);
    send_edge('0);
    repeat (7) send_step(2999);
    repeat (2) send_step(500);
    send_step(3001);
    wait_idle();
  endtask

  task automatic test_sync_thresholds();
    gap_pct   = 20;
    stall_pct = 46;
    write_sync_threshold('0);
    send_step(0);
    send_step(0);
    send_step(1);
    send_frame(6, 1'b1);
    send_frame(4, 1'b1);
    wait_idle();
    write_sync_threshold('1);
    send_step(65535);
    send_step(0);
    send_step(40000);
    send_frame(11, 1'b0);
    repeat (4) send_edge(TimeW'($urandom_range(0, 65535)));
    wait_idle();
  endtask

  task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                     input bit hold_off);
    int  target;
    int  roll;
    bit  paused;
    wait_idle();
    gap_pct   = send_pct;
    stall_pct = recv_pct;
    write_sync_threshold(TimeW'($urandom_range(1500, 6000)));
    target = n_sent + 130;
    paused = 1'b0;
    while (n_sent < target) begin
      roll = $urandom_range(0, 99);
      if (roll < 10) begin
        send_edge(TimeW'($urandom_range(0, 65535)));
      end else if (roll < 20) begin
        send_frame($urandom_range(1, 3), 1'($urandom_range(0, 1)));
      end else begin
        send_frame($urandom_range(2, 12), 1'b1);
      end
      if (hold_off && !paused && n_sent > target - 65) begin
        wait_idle();
        paused = 1'b1;
      end
    end
    wait_idle();
  endtask

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  always @(posedge clk) begin : check_results
    cfd_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result word with nothing pending", 0, 0);
      end else begin
        want = pending_results.pop_front();
        n_checked++;
        if (want.width_valid) n_widths++;
        if (want.frame_complete) n_complete++;
        if (width_valid !== want.width_valid)
          report_mismatch("width_valid", width_valid, want.width_valid);
        if (channel_index !== want.channel_index)
          report_mismatch("channel_index", channel_index, want.channel_index);
        if (pulse_width !== want.pulse_width)
          report_mismatch("pulse_width", pulse_width, want.pulse_width);
        if (frame_complete !== want.frame_complete)
          report_mismatch("frame_complete", frame_complete, want.frame_complete);
        if (sync_locked !== want.sync_locked)
          report_mismatch("sync_locked", sync_locked, want.sync_locked);
        if (learned_channels !== want.learned_channels)
          report_mismatch("learned_channels", learned_channels, want.learned_channels);
      end
    end
  end

  // no word moving on either channel for too long means a hang
  always @(posedge clk) begin
    if (rst || psel || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("timeout: %0d results still pending", pending_results.size());
      $display("cppm_frame_decoder verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_first_frames();
    test_sync_thresholds();
    test_random_traffic(20, 46, 1'b1);
    test_random_traffic(46, 20, 1'b0);
    test_random_traffic(0, 0, 1'b0);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("covered %0d edge words, %0d results checked, %0d widths, %0d completions",
             n_sent, n_checked, n_widths, n_complete);
    $display("thresholds 0, 65535, reset value and random; timer wrap and slot overflow");
    if (n_errors == 0) begin
      $display("cppm_frame_decoder verification clean");
    end else begin
      $display("cppm_frame_decoder verification failed");
    end
    $finish;
  end

endmodule
